// ===== hw/rtl/lks_pkg.sv =====
// Package for the LFSR keystream scrambler: header and seed masks, widths,
// the seed builder and the unrolled triple clock of the 24-bit LFSR.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lks_pkg;

  localparam int KEY_LENGTH = 100;
  localparam int CLOCKS_PER_TRIPLE = 24;
  localparam int KIDX_W = $clog2(KEY_LENGTH);

  localparam logic [7:0] HDR_MASK_1 = 8'h42;
  localparam logic [7:0] HDR_MASK_2 = 8'h53;
  localparam logic [7:0] SEED_MASK_A = 8'h53;
  localparam logic [7:0] SEED_MASK_B = 8'h55;
  localparam logic [7:0] SEED_MASK_C = 8'h4E;

  typedef logic [KIDX_W-1:0] kidx_t;
  typedef logic [23:0] lfsr_t;

  // Byte position in the region, saturating once the payload is reached.
  typedef enum logic [1:0] {
    POS_VERSION = 2'd0,
    POS_HDR1    = 2'd1,
    POS_HDR2    = 2'd2,
    POS_PAYLOAD = 2'd3
  } pos_t;

  // Byte lane of the current LFSR state that feeds the keystream.
  typedef enum logic [1:0] {
    LANE_A = 2'd0,
    LANE_B = 2'd1,
    LANE_C = 2'd2
  } lane_t;

  typedef struct packed {
    logic  load;
    logic  clear_index;
    logic  advance;
    lfsr_t seed;
  } kgen_ctrl_t;

  function automatic lfsr_t make_seed(input logic [3:0] t1, input logic [3:0] t2,
                                      input logic [3:0] t3, input logic [3:0] t4);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    a = {t1, t2} ^ SEED_MASK_A;
    b = {t3, t4} ^ SEED_MASK_B;
    c = {t3, t2} ^ SEED_MASK_C;
    return {a, b, c};
  endfunction

  function automatic lfsr_t clock_triple(input lfsr_t s_in);
    lfsr_t s;
    logic  fb;
    s = s_in;
    for (int i = 0; i < CLOCKS_PER_TRIPLE; i++) begin
      fb = s[0] ^ s[17] ^ s[22] ^ s[23];
      s = {fb, s[23:1]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lks_if.sv =====
// Valid/ready channel interfaces for the scrambler input and result streams.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lks_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_in;
  logic        last;
  logic        mode;
  logic [11:0] seed;

  modport source (output valid, data_in, last, mode, seed, input ready);
  modport sink (input valid, data_in, last, mode, seed, output ready);
endinterface

interface lks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       key_ok;
  logic       last_out;

  modport source (output valid, data_out, key_ok, last_out, input ready);
  modport sink (input valid, data_out, key_ok, last_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lks_keygen.sv =====
// Keystream generator: seed register, LFSR state and keystream index.
// Depends on lks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lks_keygen (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lks_pkg::kgen_ctrl_t ctrl,
  output lks_pkg::lfsr_t          seed_reg,
  output logic [7:0]              key_byte
);
  import lks_pkg::*;

  lfsr_t lfsr;
  kidx_t key_index;
  lane_t lane;

  always_comb begin
    unique case (lane)
      LANE_A:  key_byte = lfsr[23:16];
      LANE_B:  key_byte = lfsr[15:8];
      LANE_C:  key_byte = lfsr[7:0];
      default: key_byte = lfsr[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg  <= '0;
      lfsr      <= '0;
      key_index <= '0;
      lane      <= LANE_A;
    end else begin
      if (ctrl.load) begin
        seed_reg <= ctrl.seed;
        lfsr     <= ctrl.seed;
      end
      if (ctrl.clear_index) begin
        key_index <= '0;
        lane      <= LANE_A;
      end else if (ctrl.advance) begin
        if (key_index == kidx_t'(KEY_LENGTH - 1)) begin
          key_index <= '0;
          lane      <= LANE_A;
          lfsr      <= seed_reg;
        end else begin
          key_index <= key_index + kidx_t'(1);
          unique case (lane)
            LANE_A:  lane <= LANE_B;
            LANE_B:  lane <= LANE_C;
            default: begin
              lane <= LANE_A;
              lfsr <= clock_triple(lfsr);
            end
          endcase
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfsr_keystream_scrambler.sv =====
// Top level of the LFSR keystream scrambler: header handling, key check and
// the result register. Depends on lks_pkg, lks_if and lks_keygen.
// A result is registered and is valid in the cycle after its input transfer.
// Throughput: one byte per cycle; the 24 LFSR shift steps per key triple are
// unrolled XOR logic in the keystream generator, and a held result stalls input.
// Reset clears the byte position, key check, mode and keystream state.
`timescale 1ns / 1ps
`default_nettype none

module lfsr_keystream_scrambler (
  input wire logic clk,
  input wire logic rst,
  lks_in_if.sink   in_chan,
  lks_out_if.source out_chan
);
  import lks_pkg::*;

  pos_t       pos;
  logic       packet_mode;
  logic       check_passed;
  logic [7:0] first_hdr;

  logic       out_valid;
  logic [7:0] out_data;
  logic       out_key_ok;
  logic       out_last;

  kgen_ctrl_t kctrl;
  lfsr_t      seed_reg;
  logic [7:0] key_byte;

  logic       accept;
  logic       mode_next;
  logic       check_next;
  logic [7:0] res_next;
  logic [7:0] j2;

  lks_keygen u_keygen (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (kctrl),
    .seed_reg (seed_reg),
    .key_byte (key_byte)
  );

  assign in_chan.ready     = !out_valid || out_chan.ready;
  assign accept            = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.data_out = out_data;
  assign out_chan.key_ok   = out_key_ok;
  assign out_chan.last_out = out_last;
  assign j2                = in_chan.data_in ^ HDR_MASK_2;

  always_comb begin
    mode_next   = packet_mode;
    check_next  = check_passed;
    res_next    = in_chan.data_in;
    kctrl       = '0;
    kctrl.seed  = make_seed(in_chan.seed[11:8], in_chan.seed[7:4], in_chan.seed[3:0],
                            in_chan.seed[7:4] ^ 4'd1);
    unique case (pos)
      POS_VERSION: begin
        mode_next         = in_chan.mode;
        check_next        = in_chan.mode;
        kctrl.clear_index = 1'b1;
        kctrl.load        = in_chan.mode;
      end
      POS_HDR1: begin
        if (packet_mode) begin
          res_next = seed_reg[23:16] ^ SEED_MASK_A ^ HDR_MASK_1;
        end
      end
      POS_HDR2: begin
        kctrl.clear_index = 1'b1;
        if (packet_mode) begin
          res_next = seed_reg[15:8] ^ SEED_MASK_B ^ HDR_MASK_2;
        end else begin
          kctrl.seed = make_seed(first_hdr[7:4], first_hdr[3:0], j2[7:4], j2[3:0]);
          check_next = (j2[3:0] == (first_hdr[3:0] ^ 4'd1));
          kctrl.load = check_next;
        end
      end
      default: begin
        if (check_passed) begin
          res_next      = in_chan.data_in ^ key_byte;
          kctrl.advance = 1'b1;
        end
      end
    endcase
    if (!accept) begin
      kctrl.load        = 1'b0;
      kctrl.clear_index = 1'b0;
      kctrl.advance     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_VERSION;
      packet_mode  <= 1'b0;
      check_passed <= 1'b0;
      first_hdr    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        packet_mode  <= mode_next;
        check_passed <= check_next;
        if (pos == POS_HDR1 && !packet_mode) begin
          first_hdr <= in_chan.data_in ^ HDR_MASK_1;
        end
        if (in_chan.last) begin
          pos <= POS_VERSION;
        end else begin
          unique case (pos)
            POS_VERSION: pos <= POS_HDR1;
            POS_HDR1:    pos <= POS_HDR2;
            default:     pos <= POS_PAYLOAD;
          endcase
        end
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data   <= res_next;
      out_key_ok <= check_next;
      out_last   <= in_chan.last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for lfsr_keystream_scrambler: a byte-level predictor
// in a scoreboard class, valid/ready drivers with bursts and stalls, a watchdog.
// Depends on lks_pkg, lks_if and the scrambler RTL.
`timescale 1ns / 1ps

class scrambler_scoreboard;
  typedef struct packed {
    logic [7:0] data;
    logic       key_ok;
    logic       last;
  } byte_result_t;

  byte_result_t expected_bytes[$];
  int           pos;
  logic [7:0]   hdr_j1;
  logic [23:0]  seed_reg;
  logic [23:0]  lfsr;
  int           kidx;
  logic         passed;
  logic         encrypting;
  int           errors;
  int           checked;

  function new();
    pos = 0;
    hdr_j1 = '0;
    seed_reg = '0;
    lfsr = '0;
    kidx = 0;
    passed = 1'b0;
    encrypting = 1'b0;
    errors = 0;
    checked = 0;
  endfunction

  function logic [23:0] seed_from_nibbles(logic [3:0] t1, logic [3:0] t2,
                                          logic [3:0] t3, logic [3:0] t4);
    return {{t1, t2} ^ lks_pkg::SEED_MASK_A, {t3, t4} ^ lks_pkg::SEED_MASK_B,
            {t3, t2} ^ lks_pkg::SEED_MASK_C};
  endfunction

  // Taps 0, 17, 22 and 23 feed the new top bit on each right shift.
  function logic [23:0] run_triple(logic [23:0] s);
    for (int n = 0; n < lks_pkg::CLOCKS_PER_TRIPLE; n++)
      s = {^(s & 24'hC20001), s[23:1]};
    return s;
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  function void note_input(logic [7:0] d, logic lst, logic m, logic [11:0] sd);
    byte_result_t r;
    logic [7:0]   j2;
    logic [7:0]   kb;
    lks_pkg::lane_t ln;
    r.data = d;
    if (pos == 0) begin
      encrypting = m;
      passed = 1'b0;
      kidx = 0;
      if (m) begin
        seed_reg = seed_from_nibbles(sd[11:8], sd[7:4], sd[3:0], sd[7:4] ^ 4'h1);
        lfsr = seed_reg;
        passed = 1'b1;
      end
    end else if (pos == 1) begin
      if (encrypting) r.data = seed_reg[23:16] ^ lks_pkg::SEED_MASK_A ^ lks_pkg::HDR_MASK_1;
      else hdr_j1 = d ^ lks_pkg::HDR_MASK_1;
    end else if (pos == 2) begin
      if (encrypting) begin
        r.data = seed_reg[15:8] ^ lks_pkg::SEED_MASK_B ^ lks_pkg::HDR_MASK_2;
      end else begin
        j2 = d ^ lks_pkg::HDR_MASK_2;
        if (j2[3:0] == (hdr_j1[3:0] ^ 4'h1)) begin
          seed_reg = seed_from_nibbles(hdr_j1[7:4], hdr_j1[3:0], j2[7:4], j2[3:0]);
          lfsr = seed_reg;
          passed = 1'b1;
        end else begin
          passed = 1'b0;
        end
      end
      kidx = 0;
    end else if (passed) begin
      ln = lks_pkg::lane_t'(kidx % 3);
      case (ln)
        lks_pkg::LANE_A: kb = lfsr[23:16];
        lks_pkg::LANE_B: kb = lfsr[15:8];
        default: kb = lfsr[7:0];
      endcase
      r.data = d ^ kb;
      if (ln == lks_pkg::LANE_C) lfsr = run_triple(lfsr);
      kidx++;
      if (kidx >= lks_pkg::KEY_LENGTH) begin
        kidx = 0;
        lfsr = seed_reg;
      end
    end
    r.key_ok = passed;
    r.last = lst;
    expected_bytes.insert(expected_bytes.size(), r);
    if (lst) pos = 0;
    else if (pos < 255) pos++;
  endfunction

  function void check_result(logic [7:0] d, logic k, logic l);
    byte_result_t r;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result transfer: data_out %0h key_ok %0b last_out %0b", d, k, l);
      errors++;
      return;
    end
    r = expected_bytes.pop_front();
    checked++;
    if (d !== r.data) begin
      $error("data_out mismatch: expected %0h, actual %0h", r.data, d);
      errors++;
    end
    if (k !== r.key_ok) begin
      $error("key_ok mismatch: expected %0b, actual %0b", r.key_ok, k);
      errors++;
    end
    if (l !== r.last) begin
      $error("last_out mismatch: expected %0b, actual %0b", r.last, l);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import lks_pkg::*;

  typedef enum int {REG_ENCRYPT, REG_DEC_GOOD, REG_DEC_BAD, REG_DEC_NOISE} region_kind_t;
  typedef enum int {RDY_FREE, RDY_COIN, RDY_SPARSE, RDY_BLOCKED} stall_style_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 400;

  logic clk;
  logic rst;

  lks_in_if  in_if();
  lks_out_if out_if();

  lfsr_keystream_scrambler u_dut (
    .clk(clk),
    .rst(rst),
    .in_chan(in_if),
    .out_chan(out_if)
  );

  scrambler_scoreboard sb;
  int           burst_left;
  int           items_sent;
  int           regions [4];
  int           idle_cycles;
  stall_style_t stall_style;
  int           style_left;
  int           rdy_cycle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(20, 80);
    end
    style_left--;
    rdy_cycle++;
    case (stall_style)
      RDY_FREE: out_if.ready <= 1'b1;
      RDY_COIN: out_if.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_if.ready <= (rdy_cycle % 4 == 0);
      default: out_if.ready <= (rdy_cycle % 16 >= 11);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.data_out, out_if.key_ok, out_if.last_out);
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.data_in, in_if.last, in_if.mode, in_if.seed);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l, input logic m,
                           input logic [11:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data_in <= d;
    in_if.last <= l;
    in_if.mode <= m;
    in_if.seed <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_region(input region_kind_t kind, input logic [11:0] key,
                             input int len, input int fill);
    logic [7:0]  d;
    logic        m;
    logic [11:0] s;
    logic [3:0]  bad;
    bad = 4'($urandom_range(1, 15));
    regions[kind]++;
    for (int i = 0; i < len; i++) begin
      d = (fill < 0) ? 8'($urandom) : fill[7:0];
      m = 1'($urandom);
      s = 12'($urandom);
      if (i == 0) begin
        m = (kind == REG_ENCRYPT);
        if (kind == REG_ENCRYPT) s = key;
      end else if (i == 1 && (kind == REG_DEC_GOOD || kind == REG_DEC_BAD)) begin
        d = {key[11:8], key[7:4]} ^ HDR_MASK_1;
      end else if (i == 2 && kind == REG_DEC_GOOD) begin
        d = {key[3:0], key[7:4] ^ 4'h1} ^ HDR_MASK_2;
      end else if (i == 2 && kind == REG_DEC_BAD) begin
        d = {key[3:0], key[7:4] ^ 4'h1 ^ bad} ^ HDR_MASK_2;
      end
      send_byte(d, i == len - 1, m, s);
    end
  endtask

  initial begin
    int           start;
    int           r;
    int           len;
    int           region_no;
    region_kind_t kind;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data_in = '0;
    in_if.last = 1'b0;
    in_if.mode = 1'b0;
    in_if.seed = '0;
    out_if.ready = 1'b0;
    burst_left = 0;
    items_sent = 0;
    idle_cycles = 0;
    style_left = 0;
    rdy_cycle = 0;
    stall_style = RDY_FREE;
    regions = '{default: 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_region(REG_ENCRYPT, 12'h000, 5, 0);
    send_region(REG_ENCRYPT, 12'hFFF, 4, 255);
    send_region(REG_DEC_GOOD, 12'h5A3, 5, -1);
    send_region(REG_DEC_BAD, 12'hFFF, 4, 255);
    send_region(REG_DEC_NOISE, 12'h000, 1, -1);
    send_region(REG_ENCRYPT, 12'($urandom), 2, -1);
    send_region(REG_DEC_GOOD, 12'h000, 3, 0);
    wait_drained();

    start = items_sent;
    region_no = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      kind = (r < 45) ? REG_DEC_GOOD : (r < 75) ? REG_ENCRYPT :
             (r < 85) ? REG_DEC_BAD : REG_DEC_NOISE;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(90, 130) : $urandom_range(1, 30);
      if (region_no == 6) len = 300;
      send_region(kind, 12'($urandom), len, -1);
      region_no++;
      if (region_no % 8 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d bytes in %0d encrypt, %0d good-key, %0d bad-key and %0d noise regions,",
             items_sent, regions[REG_ENCRYPT], regions[REG_DEC_GOOD],
             regions[REG_DEC_BAD], regions[REG_DEC_NOISE]);
    $display("including keystream wrap and position saturation; %0d results checked.",
             sb.checked);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
